// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    // screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int OROW_W = 5;
    localparam int OCOL_W = 7;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int SUM_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_USED_W  = POS_W + OROW_W + OCOL_W + CHAR_W + ATTR_W;

    // control bytes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    // logical cell address to memory address, rows rotated by the scroll base
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] lin,
                                                    input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, lin} + {1'b0, base};
        if (sum >= (ADDR_W+1)'(CELL_COUNT)) begin
            sum = sum - (ADDR_W+1)'(CELL_COUNT);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/tcw_screen_ram.sv =====
module tcw_screen_ram (
    input  logic                   aclk,
    input  tcw_pkg::ram_wr_t       wr,
    input  tcw_pkg::ram_rd_t       rd,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcw_pkg::CMD_W-1:0]       command,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::IDX_W-1:0]       cell_index,
    input  logic [tcw_pkg::ATTR_W-1:0]      text_attribute,
    output tcw_pkg::ram_wr_t                ram_wr,
    output tcw_pkg::ram_rd_t                ram_rd,
    input  logic [tcw_pkg::CELL_W-1:0]      ram_rd_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(SCREEN_COLUMNS);

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]   sweep_left_reg, sweep_left_next;
    logic [CELL_W-1:0]   fill_reg, fill_next;
    logic                sweep_item_reg, sweep_item_next;
    logic                rd_flag_reg, rd_flag_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [ADDR_W-1:0]   lin;
    logic [COL_W:0]      col_ext, col_adv;
    logic [ROW_W:0]      row_adv;
    logic                row_inc, is_print, do_scroll;
    logic [ADDR_W:0]     top_adv;
    logic [SUM_W-1:0]    idx_w;
    logic [CHAR_W-1:0]   res_char;
    logic [ATTR_W-1:0]   res_attr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= ADDR_W'(CELL_COUNT - 1);
            fill_reg       <= {RESET_ATTR, BLANK_CHAR};
            sweep_item_reg <= 1'b0;
            rd_flag_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_left_reg <= sweep_left_next;
            fill_reg       <= fill_next;
            sweep_item_reg <= sweep_item_next;
            rd_flag_reg    <= rd_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    // cursor step for a put
    always_comb begin
        col_ext  = {1'b0, col_reg};
        col_adv  = col_ext;
        row_inc  = 1'b0;
        is_print = 1'b0;
        case (char_code)
            CHAR_LF: begin
                col_adv = '0;
                row_inc = 1'b1;
            end
            CHAR_CR: begin
                col_adv = '0;
            end
            CHAR_TAB: begin
                col_adv = (col_ext + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
            end
            CHAR_BS: begin
                if (col_reg != '0) begin
                    col_adv = col_ext - (COL_W+1)'(1);
                end
            end
            default: begin
                is_print = 1'b1;
                col_adv  = col_ext + (COL_W+1)'(1);
            end
        endcase
        if (col_adv >= (COL_W+1)'(SCREEN_COLUMNS)) begin
            col_adv = '0;
            row_inc = 1'b1;
        end
        row_adv   = {1'b0, row_reg} + (ROW_W+1)'(row_inc);
        do_scroll = (row_adv >= (ROW_W+1)'(SCREEN_ROWS));
    end

    always_comb begin
        lin     = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
        top_adv = {1'b0, top_reg} + {1'b0, COLS_A};
        idx_w   = SUM_W'(cell_index);

        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        fill_next       = fill_reg;
        sweep_item_next = sweep_item_reg;
        rd_flag_next    = rd_flag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        ram_wr          = '0;
        ram_rd          = '0;
        s_tready        = 1'b0;
        res_char        = rd_flag_reg ? ram_rd_data[CHAR_W-1:0] : '0;
        res_attr        = rd_flag_reg ? ram_rd_data[CELL_W-1:CHAR_W] : '0;

        case (state_reg)
            ST_INIT, ST_SWEEP: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = sweep_addr_reg;
                ram_wr.data = fill_reg;
                if (sweep_left_reg == '0) begin
                    state_next = sweep_item_reg ? ST_DONE : ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                    sweep_left_next = sweep_left_reg - ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next   = ST_DONE;
                    rd_flag_next = 1'b0;
                    case (cmd_t'(command))
                        CMD_PUT: begin
                            if (is_print) begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = phys_addr(lin, top_reg);
                                ram_wr.data = {text_attribute, char_code};
                            end
                            col_next = col_adv[COL_W-1:0];
                            if (do_scroll) begin
                                // old top row becomes the new bottom row
                                row_next        = ROW_W'(SCREEN_ROWS - 1);
                                top_next        = (top_adv >= (ADDR_W+1)'(CELL_COUNT)) ?
                                                  '0 : top_adv[ADDR_W-1:0];
                                sweep_addr_next = top_reg;
                                sweep_left_next = ADDR_W'(SCREEN_COLUMNS - 1);
                                fill_next       = {text_attribute, BLANK_CHAR};
                                sweep_item_next = 1'b1;
                                state_next      = ST_SWEEP;
                            end else begin
                                row_next = row_adv[ROW_W-1:0];
                            end
                        end
                        CMD_READ: begin
                            if (idx_w < SUM_W'(CELL_COUNT)) begin
                                ram_rd.en    = 1'b1;
                                ram_rd.addr  = phys_addr(idx_w[ADDR_W-1:0], top_reg);
                                rd_flag_next = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            col_next        = '0;
                            row_next        = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_left_next = ADDR_W'(CELL_COUNT - 1);
                            fill_next       = {text_attribute, BLANK_CHAR};
                            sweep_item_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({res_attr, res_char, OCOL_W'(col_reg),
                                                   OROW_W'(row_reg), POS_W'(lin)});
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/text_console_char_writer.sv =====
// flow: an accepted put or read goes to ST_DONE, which loads the result register driving m_;
// a put that scrolls first blanks the new bottom row in ST_SWEEP, a clear first blanks every cell
// an item is taken only in ST_IDLE, after the last one is done; one memory write per cycle
// sets the cost of blanking and clearing; a stalled result word holds the next item at its end
// reset: aresetn low clears cursor, scroll base and output; then a pass in ST_INIT fills
// every cell with a space on attribute 0x0F while s_tready stays low
module text_console_char_writer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,   // command, char_code, cell_index
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata,   // cursor_pos, cursor_row,
                                                          // cursor_col, cell_char, cell_attr
    // attribute register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]         cfg_data   // text_attribute
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic [CELL_W-1:0] ram_rd_data;

    // unpack the input word, lowest field first
    assign command    = s_tdata[CMD_W-1:0];
    assign char_code  = s_tdata[CMD_W +: CHAR_W];
    assign cell_index = s_tdata[CMD_W+CHAR_W +: IDX_W];

    // attribute used for written and blanked cells
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= RESET_ATTR;
        end else if (cfg_valid) begin
            attr_reg <= cfg_data;
        end
    end

    // cursor, scroll base, fill sweeps and result register
    tcw_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .command        (command),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .text_attribute (attr_reg),
        .ram_wr         (ram_wr),
        .ram_rd         (ram_rd),
        .ram_rd_data    (ram_rd_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // cell store, rows rotated so that a scroll only moves the base
    tcw_screen_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/tcw_checker.sv =====
module tcw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    logic [POS_W-1:0]  pos;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;

    assign pos = m_tdata[POS_W-1:0];
    assign row = m_tdata[POS_W +: OROW_W];
    assign col = m_tdata[POS_W+OROW_W +: OCOL_W];

    // reset empties the output and holds off input during the fill pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output or input open right after reset");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(row) < SCREEN_ROWS) && (int'(col) < SCREEN_COLUMNS))
        else $error("cursor outside the screen");

    a_cursor_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pos == POS_W'(int'(row) * SCREEN_COLUMNS + int'(col)))
        else $error("linear cursor position disagrees with row and column");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
